// ===== hw/rtl/fbfl_pkg.sv =====
// shared types, constants and helpers for the fixed-block free-list allocator
`default_nettype none
package fbfl_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int BI_W       = 8;

	typedef enum logic [1:0] {
		CMD_GET    = 2'd0,
		CMD_PUT    = 2'd1,
		CMD_REINIT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} stat_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} link_rd_t;

	// successor of a block in the freshly built chain, last one wraps to 0
	function automatic logic [IDX_W-1:0] link_default(input logic [IDX_W-1:0] addr);
		logic [IDX_W-1:0] nxt;
		if (addr == IDX_W'(NUM_BLOCKS - 1)) begin
			nxt = '0;
		end else begin
			nxt = addr + IDX_W'(1);
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fbfl_link_ram.sv =====
// link table memory with per-entry valid bits that fall back to the initial chain
`default_nettype none
module fbfl_link_ram
	import fbfl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire link_wr_t         wr,
	input  wire link_rd_t         rd,
	input  wire logic             clear,
	output logic      [IDX_W-1:0] rd_data
);

	logic [IDX_W-1:0]      mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] vld_q;
	logic [IDX_W-1:0]      rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= vld_q[rd.addr] ? mem[rd.addr] : link_default(rd.addr);
		end
	end

	// unwritten entries read as the rebuilt chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_block_free_list_allocator.sv =====
// top level of the fixed-block free-list allocator
`default_nettype none
// Hands out and takes back blocks of a pool of NUM_BLOCKS equal-sized blocks,
// named by index. Each request word carries a command (get, put, reinit) and,
// for a put, the returned block index; each request gives exactly one response
// word with the granted index, a status, the free count after the command and
// empty/full flags. The link table is a synchronous memory, so a get issues its
// read of the head block's successor in the accept cycle and pops in the execute
// step. Put and reinit go through the same two steps. Reinit is done in those
// steps too: per-entry valid bits are cleared at once and an unwritten entry
// reads as the rebuilt chain, so there is no clearing pass after reset or
// reinit. The response sits in an output register, so a new request is accepted
// while the previous response still waits under rsp_stall; the block then holds
// in its execute step until that register frees up. A new request is taken only
// once the previous one has left its execute step.
module fixed_block_free_list_allocator
	import fbfl_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request channel
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire logic [1:0]       command,
	input  wire logic [BI_W-1:0]  block_index,
	// response channel
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output logic      [IDX_W-1:0] granted_index,
	output logic      [1:0]       status,
	output logic      [CNT_W-1:0] free_blocks,
	output logic                  pool_empty,
	output logic                  pool_full
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [BI_W-1:0]  idx_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;

	// response register
	logic             rsp_valid_q;
	logic [IDX_W-1:0] rsp_grant_q;
	stat_t            rsp_status_q;
	logic [CNT_W-1:0] rsp_free_q;
	logic             rsp_empty_q;
	logic             rsp_full_q;

	link_wr_t         link_wr;
	link_rd_t         link_rd;
	logic             link_clear;
	logic [IDX_W-1:0] link_rdata;

	logic             accept;
	logic             rsp_take;
	logic             finish;

	// next-state values computed in the execute step
	logic [IDX_W-1:0] head_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	logic [IDX_W-1:0] grant_nxt;
	stat_t            status_nxt;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	// execute completes once the response register is free or draining
	assign finish    = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);

	// always look up the successor of the current head on accept
	always_comb begin
		link_rd.en   = accept;
		link_rd.addr = head_q;
	end

	always_comb begin
		head_nxt     = head_q;
		cnt_nxt      = cnt_q;
		grant_nxt    = '0;
		status_nxt   = ST_OK;
		link_wr.en   = 1'b0;
		link_wr.addr = IDX_W'(idx_q);
		link_wr.data = head_q;
		link_clear   = 1'b0;
		unique case (cmd_q)
			CMD_GET: begin
				if (cnt_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					// pop: the head block goes out, its successor becomes head
					grant_nxt = head_q;
					head_nxt  = link_rdata;
					cnt_nxt   = cnt_q - CNT_W'(1);
				end
			end
			CMD_PUT: begin
				priority if (32'(idx_q) >= 32'(NUM_BLOCKS)) begin
					status_nxt = ST_RANGE;
				end else if (cnt_q == CNT_W'(NUM_BLOCKS)) begin
					// pool full, refuse rather than overcount
					status_nxt = ST_FULL;
				end else begin
					// push: returned block links to the old head
					link_wr.en = finish;
					head_nxt   = IDX_W'(idx_q);
					cnt_nxt    = cnt_q + CNT_W'(1);
				end
			end
			CMD_REINIT: begin
				link_clear = finish;
				head_nxt   = '0;
				cnt_nxt    = CNT_W'(NUM_BLOCKS);
			end
			default: begin
				// unused code, no operation
			end
		endcase
	end

	fbfl_link_ram u_link_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (link_wr),
		.rd      (link_rd),
		.clear   (link_clear),
		.rd_data (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= CNT_W'(NUM_BLOCKS);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q <= S_IDLE;
						head_q  <= head_nxt;
						cnt_q   <= cnt_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// captured request word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			idx_q <= block_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_grant_q  <= grant_nxt;
			rsp_status_q <= status_nxt;
			rsp_free_q   <= cnt_nxt;
			rsp_empty_q  <= (cnt_nxt == '0);
			rsp_full_q   <= (cnt_nxt == CNT_W'(NUM_BLOCKS));
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign granted_index = rsp_grant_q;
	assign status        = rsp_status_q;
	assign free_blocks   = rsp_free_q;
	assign pool_empty    = rsp_empty_q;
	assign pool_full     = rsp_full_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_BLOCKS))
		else $error("free count above pool size");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted word did not enter execute");

	a_get_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && cmd_q == CMD_GET && cnt_q != '0) |=>
		(cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("successful get did not drop the free count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_EMPTY) |-> (pool_empty && free_blocks == '0))
		else $error("empty status without empty pool");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> rsp_valid_q)
		else $error("stalled response word dropped");
`endif

endmodule
`default_nettype wire
